// ----- sv/ffir_pkg.sv -----
package ffir_pkg;

   localparam int TAP_W     = 16;
   localparam int SAMPLE_W  = 12;
   localparam int TAP_IDX_W = 7;
   localparam int FILT_W    = 25;
   localparam int POS_OUT_W = 8;
   localparam int CSR_W     = 9;
   // signed tap times zero-extended sample
   localparam int PROD_W    = TAP_W + SAMPLE_W + 1;

   localparam logic [CSR_W-1:0] CSR_RESET = 9'd256;

   localparam logic MODE_FILTER = 1'b0;
   localparam logic MODE_LOAD   = 1'b1;

   localparam logic signed [FILT_W-1:0] FILT_MAX = {1'b0, {(FILT_W-1){1'b1}}};
   localparam logic signed [FILT_W-1:0] FILT_MIN = {1'b1, {(FILT_W-1){1'b0}}};

   typedef struct packed {
      logic                     mode;
      logic [SAMPLE_W-1:0]      sample;
      logic [TAP_IDX_W-1:0]     tap_index;
      logic signed [TAP_W-1:0]  tap_value;
   } req_type;

   typedef struct packed {
      logic signed [FILT_W-1:0] filtered;
      logic [POS_OUT_W-1:0]     position;
      logic                     frame_end;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctl_type;

endpackage

// ----- sv/framed_fir_filter.sv -----
// A sample transfer yields its result after the tap rotation through the cell row
// and the bit-serial divider that follows, which works on ACC_W = 29 + clog2(TAPS)
// bits. A new sample is taken only after the last result has entered the output
// register. Coefficient transfers are taken only between samples and give no
// result. Synchronous active-high reset clears taps, history and frame position;
// length is 256.
module framed_fir_filter #(
   parameter int TAPS      = 128,
   parameter int MAX_FRAME = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ffir_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ffir_pkg::rsp_type               rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [ffir_pkg::CSR_W-1:0]      csr_wr_data
);

   localparam int CNT_W = $clog2(TAPS);
   localparam int POS_W = $clog2(MAX_FRAME);
   localparam int LEN_W = $clog2(MAX_FRAME + 1);
   localparam int CMP_W = (LEN_W > ffir_pkg::CSR_W) ? LEN_W : ffir_pkg::CSR_W;
   localparam int ACC_W = ffir_pkg::PROD_W + $clog2(TAPS);
   // divisor is 5 * length, below 8 * length
   localparam int DIV_W = LEN_W + 3;

   localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(TAPS - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(ffir_pkg::FILT_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(ffir_pkg::FILT_MIN);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MAC,
      S_DIV,
      S_OUT
   } state_type;

   state_type                   state_ff;
   logic [ffir_pkg::CSR_W-1:0]  csr_ff;
   logic [POS_W-1:0]            frame_pos_ff;
   logic [POS_W-1:0]            pos_ff;
   logic                        end_ff;
   logic [DIV_W-1:0]            dsr_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic                        rsp_valid_ff;
   ffir_pkg::rsp_type           rsp_ff;

   logic [LEN_W-1:0]            eff_len;
   logic [POS_W-1:0]            pos_now;
   logic [LEN_W-1:0]            pos_inc;
   logic                        pos_last;
   logic                        hist_clear;
   logic                        req_take;
   logic                        sample_take;
   logic                        load_take;
   ffir_pkg::cell_ctl_type      cell_ctl;

   logic signed [ffir_pkg::TAP_W-1:0]  tap_q  [TAPS];
   logic [ffir_pkg::SAMPLE_W-1:0]      hist_q [TAPS];

   logic signed [ffir_pkg::PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]            addend;
   logic signed [ACC_W-1:0]            acc_in;

   logic                        div_start;
   logic                        div_done;
   logic signed [ACC_W-1:0]     div_quo;
   logic signed [ffir_pkg::FILT_W-1:0] filt_sat;
   logic                        rsp_load;

   // Length register: written whenever the enable is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= ffir_pkg::CSR_RESET;
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   // Effective frame length: zero counts as one, clamp at MAX_FRAME.
   always_comb begin
      priority if (csr_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (CMP_W'(csr_ff) > CMP_W'(MAX_FRAME)) begin
         eff_len = LEN_W'(MAX_FRAME);
      end else begin
         eff_len = LEN_W'(csr_ff);
      end
   end

   // A stored position at or past a shortened length starts a new frame.
   assign pos_now    = (LEN_W'(frame_pos_ff) >= eff_len) ? '0 : frame_pos_ff;
   assign pos_inc    = LEN_W'(pos_now) + LEN_W'(1);
   assign pos_last   = (pos_inc == eff_len);
   assign hist_clear = (pos_now == '0);

   // Take items only between samples; one at a time.
   assign req_stall   = (state_ff != S_IDLE);
   assign req_take    = req_valid && (state_ff == S_IDLE);
   assign sample_take = req_take && (req_payload.mode == ffir_pkg::MODE_FILTER);
   assign load_take   = req_take && (req_payload.mode == ffir_pkg::MODE_LOAD);

   assign cell_ctl.shift  = sample_take;
   assign cell_ctl.rotate = (state_ff == S_MAC);

   // Cell row: each cell holds one tap and one history sample. A sample transfer
   // shifts history by one (zeroing older entries at frame start). During the
   // MAC phase the row rotates toward cell 0 once per cycle, so cell 0 presents
   // tap j and history j at count j; after TAPS steps every pair is home again.
   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      logic [ffir_pkg::SAMPLE_W-1:0] shift_data;

      if (k == 0) begin : g_head
         assign shift_data = req_payload.sample;
      end else begin : g_body
         assign shift_data = hist_clear ? '0 : hist_q[k-1];
      end

      ffir_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .tap_we      (load_take && (32'(req_payload.tap_index) == k)),
         .tap_wr_data (req_payload.tap_value),
         .shift_data  (shift_data),
         .tap_rot     (tap_q[(k + 1) % TAPS]),
         .hist_rot    (hist_q[(k + 1) % TAPS]),
         .tap_q       (tap_q[k]),
         .hist_q      (hist_q[k])
      );
   end

   // Single shared MAC at the head of the row; drop taps past the frame start.
   assign prod   = tap_q[0] * $signed({1'b0, hist_q[0]});
   assign addend = (32'(cnt_ff) <= 32'(pos_ff)) ? ACC_W'(prod) : '0;
   assign acc_in = acc_ff + addend;

   // Hand the finished sum to the divider on the last rotation step.
   assign div_start = (state_ff == S_MAC) && (cnt_ff == CNT_LAST);

   ffir_div #(
      .ACC_W (ACC_W),
      .DIV_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_in),
      .divisor  (dsr_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Saturate the quotient to the output range.
   always_comb begin
      priority if (div_quo > SAT_HI) begin
         filt_sat = ffir_pkg::FILT_MAX;
      end else if (div_quo < SAT_LO) begin
         filt_sat = ffir_pkg::FILT_MIN;
      end else begin
         filt_sat = ffir_pkg::FILT_W'(div_quo);
      end
   end

   // Load the output register when it is empty or being drained this cycle.
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         frame_pos_ff <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (sample_take) begin
                  state_ff     <= S_MAC;
                  cnt_ff       <= '0;
                  acc_ff       <= '0;
                  pos_ff       <= pos_now;
                  end_ff       <= pos_last;
                  dsr_ff       <= DIV_W'({eff_len, 2'b00}) + DIV_W'(eff_len);
                  frame_pos_ff <= pos_last ? '0 : POS_W'(pos_inc);
               end
            end
            S_MAC: begin
               acc_ff <= acc_in;
               if (cnt_ff == CNT_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (rsp_load) begin
            rsp_valid_ff       <= 1'b1;
            rsp_ff.filtered    <= filt_sat;
            rsp_ff.position    <= ffir_pkg::POS_OUT_W'(pos_ff);
            rsp_ff.frame_end   <= end_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide phase");

   a_mac_exit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MAC) && (cnt_ff == CNT_LAST)) |=> (state_ff == S_DIV))
      else $error("MAC phase did not hand over after the last tap");

   a_row_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (cnt_ff == '0))
      else $error("cell row left out of alignment between samples");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result raised without a finished sample");
`endif

endmodule

// ----- sv/ffir_cell.sv -----
module ffir_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ffir_pkg::cell_ctl_type               ctl,
   input  logic                                 tap_we,
   input  logic signed [ffir_pkg::TAP_W-1:0]    tap_wr_data,
   input  logic [ffir_pkg::SAMPLE_W-1:0]        shift_data,
   input  logic signed [ffir_pkg::TAP_W-1:0]    tap_rot,
   input  logic [ffir_pkg::SAMPLE_W-1:0]        hist_rot,
   output logic signed [ffir_pkg::TAP_W-1:0]    tap_q,
   output logic [ffir_pkg::SAMPLE_W-1:0]        hist_q
);

   logic signed [ffir_pkg::TAP_W-1:0] tap_ff;
   logic [ffir_pkg::SAMPLE_W-1:0]     hist_ff;

   // rotate: take the neighbor's pair; otherwise load a tap or shift history
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff  <= '0;
         hist_ff <= '0;
      end else if (ctl.rotate) begin
         tap_ff  <= tap_rot;
         hist_ff <= hist_rot;
      end else begin
         if (tap_we) begin
            tap_ff <= tap_wr_data;
         end
         if (ctl.shift) begin
            hist_ff <= shift_data;
         end
      end
   end

   assign tap_q  = tap_ff;
   assign hist_q = hist_ff;

endmodule

// ----- sv/ffir_div.sv -----
module ffir_div #(
   parameter int ACC_W = 36,
   parameter int DIV_W = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] dividend,
   input  logic [DIV_W-1:0]        divisor,
   output logic                    done,
   output logic signed [ACC_W-1:0] quotient
);

   localparam int CNT_W = $clog2(ACC_W);

   logic             busy_ff;
   logic             done_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [ACC_W-1:0] quo_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dsr_ff;

   logic [ACC_W-1:0] mag;
   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   diff;
   logic             ge;

   assign mag     = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
   assign shifted = {rem_ff, quo_ff[ACC_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign ge      = shifted >= {1'b0, dsr_ff};

   // restoring division on the magnitude, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            quo_ff  <= mag;
            rem_ff  <= '0;
            neg_ff  <= dividend[ACC_W-1];
            dsr_ff  <= divisor;
            cnt_ff  <= CNT_W'(ACC_W - 1);
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_ff <= {quo_ff[ACC_W-2:0], ge};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   // truncate toward zero: negate the magnitude quotient
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule
